>>> rtl/core/udpck_pkg.sv
// Shared types and constants for the UDP header check and checksum block.
// Used by udpck_parse and by the top level udp_header_check_and_checksum.
package udpck_pkg;

    localparam int HeaderBytes     = 8;
    localparam int HeaderKeepBytes = 6;
    localparam int MaxSegmentBytes = 65535;
    localparam int CountWidth      = 16;
    localparam int SumWidth        = 32;
    localparam int AuxWidth        = 19;
    localparam int TotalWidth      = SumWidth + 1;

    localparam logic [CountWidth-1:0] MAX_SEGMENT_COUNT = CountWidth'(MaxSegmentBytes);
    localparam logic [CountWidth-1:0] HEADER_COUNT      = CountWidth'(HeaderBytes);
    localparam logic [CountWidth-1:0] KEEP_COUNT        = CountWidth'(HeaderKeepBytes);
    localparam logic [7:0]            UDP_PROTOCOL      = 8'd17;

    typedef enum logic [2:0] {
        STATUS_OK        = 3'd0,
        STATUS_SHORT     = 3'd1,
        STATUS_SPORT_0   = 3'd2,
        STATUS_DPORT_0   = 3'd3,
        STATUS_LEN_BIG   = 3'd4
    } status_t;

    typedef struct packed {
        status_t               status;
        logic [15:0]           source_port;
        logic [15:0]           dest_port;
        logic [15:0]           length_field;
        logic [SumWidth-1:0]   word_sum;
        logic [AuxWidth-1:0]   aux_sum;
    } frame_sum_t;

endpackage

>>> rtl/core/udpck_parse.sv
// Per-frame byte parser: header field capture, word sum and pseudo header sum.
// Produces the frame summary for the byte in flight; depends on udpck_pkg.
module udpck_parse
    import udpck_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        take,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic [31:0] source_address,
    input  logic [31:0] dest_address,
    output frame_sum_t  summary
);

    logic [CountWidth-1:0] count_reg;
    logic [CountWidth-1:0] count_next;
    logic [47:0]           hdr_reg;
    logic [47:0]           hdr_next;
    logic [SumWidth-1:0]   sum_reg;
    logic [SumWidth-1:0]   sum_next;
    logic [7:0]            hold_reg;
    logic [7:0]            hold_next;
    logic [AuxWidth-1:0]   pseudo_reg;
    logic [AuxWidth-1:0]   pseudo_next;

    logic                  in_range;
    logic [2:0]            got;
    logic [47:0]           hf;
    logic [15:0]           pad;

    always_comb
    begin
        if (count_reg == '0)
        begin
            pseudo_next = AuxWidth'(source_address[31:16]) + AuxWidth'(source_address[15:0])
                        + AuxWidth'(dest_address[31:16]) + AuxWidth'(dest_address[15:0])
                        + AuxWidth'(UDP_PROTOCOL);
        end
        else
        begin
            pseudo_next = pseudo_reg;
        end

        in_range   = count_reg < MAX_SEGMENT_COUNT;
        count_next = count_reg;
        hdr_next   = hdr_reg;
        sum_next   = sum_reg;
        hold_next  = hold_reg;
        if (in_range)
        begin
            if (count_reg < KEEP_COUNT)
            begin
                hdr_next = {hdr_reg[39:0], data_byte};
            end
            if (!count_reg[0])
            begin
                hold_next = data_byte;
            end
            else
            begin
                sum_next  = sum_reg + SumWidth'({hold_reg, data_byte});
                hold_next = '0;
            end
            count_next = count_reg + CountWidth'(1);
        end
    end

    always_comb
    begin
        got = (count_next < KEEP_COUNT) ? count_next[2:0] : 3'd6;
        unique case (got)
            3'd0:    hf = '0;
            3'd1:    hf = hdr_next << 40;
            3'd2:    hf = hdr_next << 32;
            3'd3:    hf = hdr_next << 24;
            3'd4:    hf = hdr_next << 16;
            3'd5:    hf = hdr_next << 8;
            default: hf = hdr_next;
        endcase

        pad = count_next[0] ? {hold_next, 8'h00} : 16'h0000;

        summary.source_port  = hf[47:32];
        summary.dest_port    = hf[31:16];
        summary.length_field = hf[15:0];
        summary.word_sum     = sum_next;
        summary.aux_sum      = pseudo_next + AuxWidth'(hf[15:0]) + AuxWidth'(pad);

        priority if (count_next < HEADER_COUNT)
        begin
            summary.status = STATUS_SHORT;
        end
        else if (hf[47:32] == 16'h0000)
        begin
            summary.status = STATUS_SPORT_0;
        end
        else if (hf[31:16] == 16'h0000)
        begin
            summary.status = STATUS_DPORT_0;
        end
        else if (hf[15:0] > count_next)
        begin
            summary.status = STATUS_LEN_BIG;
        end
        else
        begin
            summary.status = STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            hdr_reg    <= '0;
            sum_reg    <= '0;
            hold_reg   <= '0;
            pseudo_reg <= '0;
        end
        else if (take)
        begin
            if (last_byte)
            begin
                count_reg  <= '0;
                hdr_reg    <= '0;
                sum_reg    <= '0;
                hold_reg   <= '0;
                pseudo_reg <= '0;
            end
            else
            begin
                count_reg  <= count_next;
                hdr_reg    <= hdr_next;
                sum_reg    <= sum_next;
                hold_reg   <= hold_next;
                pseudo_reg <= pseudo_next;
            end
        end
    end

endmodule

>>> rtl/core/udp_header_check_and_checksum.sv
// Top level of the UDP header check and Internet checksum block.
// Instantiates udpck_parse and depends on udpck_pkg.

// The block takes one segment byte per cycle while in_ready is high, header
// first, with the IPv4 addresses sampled on a frame's first byte, and returns one
// result on the byte marked last. Frames stream back to back at one byte per
// clock while in_ready holds; the result passes through the pipeline of summary
// register, 33-bit total register and carry fold into the output register.
// Ready drops only while that pipeline is full and the output is not being taken.
module udp_header_check_and_checksum
    import udpck_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic [31:0] source_address,
    input  logic [31:0] dest_address,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [15:0] checksum_result,
    output logic [15:0] source_port,
    output logic [15:0] dest_port,
    output logic [15:0] length_field
);

    frame_sum_t            summary;
    frame_sum_t            s1_reg;
    logic                  s1_valid_reg;
    logic [TotalWidth-1:0] total_next;
    logic [TotalWidth-1:0] total_reg;
    status_t               s2_status_reg;
    logic [15:0]           s2_sport_reg;
    logic [15:0]           s2_dport_reg;
    logic [15:0]           s2_len_reg;
    logic                  s2_valid_reg;
    logic                  out_valid_reg;
    status_t               status_reg;
    logic [15:0]           checksum_next;
    logic [15:0]           checksum_reg;
    logic [15:0]           sport_reg;
    logic [15:0]           dport_reg;
    logic [15:0]           len_reg;

    logic                  out_en;
    logic                  s2_en;
    logic                  s1_en;
    logic                  take;
    logic [17:0]           fold1;
    logic [16:0]           fold2;
    logic [15:0]           fold3;

    assign out_en   = !out_valid_reg || out_ready;
    assign s2_en    = !s2_valid_reg || out_en;
    assign s1_en    = !s1_valid_reg || s2_en;
    assign in_ready = s1_en;
    assign take     = in_valid && s1_en;

    udpck_parse u_parse (
        .clk            (clk),
        .rst_n          (rst_n),
        .take           (take),
        .data_byte      (data_byte),
        .last_byte      (last_byte),
        .source_address (source_address),
        .dest_address   (dest_address),
        .summary        (summary)
    );

    assign total_next = TotalWidth'(s1_reg.word_sum) + TotalWidth'(s1_reg.aux_sum);

    always_comb
    begin
        fold1         = {2'b00, total_reg[15:0]} + {1'b0, total_reg[32:16]};
        fold2         = {1'b0, fold1[15:0]} + {15'b0, fold1[17:16]};
        fold3         = fold2[15:0] + {15'b0, fold2[16]};
        checksum_next = ~fold3;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_en)
            begin
                s1_valid_reg <= in_valid && last_byte;
            end
            if (s2_en)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_en)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && last_byte)
        begin
            s1_reg <= summary;
        end
        if (s2_en && s1_valid_reg)
        begin
            total_reg     <= total_next;
            s2_status_reg <= s1_reg.status;
            s2_sport_reg  <= s1_reg.source_port;
            s2_dport_reg  <= s1_reg.dest_port;
            s2_len_reg    <= s1_reg.length_field;
        end
        if (out_en && s2_valid_reg)
        begin
            status_reg   <= s2_status_reg;
            checksum_reg <= checksum_next;
            sport_reg    <= s2_sport_reg;
            dport_reg    <= s2_dport_reg;
            len_reg      <= s2_len_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign checksum_result = checksum_reg;
    assign source_port     = sport_reg;
    assign dest_port       = dport_reg;
    assign length_field    = len_reg;

endmodule

>>> verif/udp_header_check_and_checksum_tb.sv
// Self-checking testbench for udp_header_check_and_checksum: directed frames, then random frames.
// Results are checked against an in-bench predictor or, for typed rows, fixed expected values.
// Depends on udpck_pkg and the RTL of the block.
`timescale 1ns / 1ps

module udp_header_check_and_checksum_tb;
    import udpck_pkg::*;

    typedef struct packed {
        status_t     status;
        logic [15:0] checksum;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [15:0] len_field;
    } udp_result_t;

    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic [31:0] sa;
        logic [31:0] da;
        logic        typed;
        udp_result_t want;
    } udp_byte_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic [15:0] checksum_result;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [15:0] length_field;

    logic [15:0] frm_count    = '0;
    logic [47:0] frm_header   = '0;
    logic [31:0] frm_word_sum = '0;
    logic [7:0]  frm_high     = '0;
    logic [31:0] frm_pseudo   = '0;

    udp_result_t pending_results[$];
    udp_byte_t   directed_rows[$];
    bit          row_typed;
    udp_result_t row_want;
    bit          no_idle;
    int          rx_hold_len;
    int          random_bytes;
    int          mismatches;

    udp_header_check_and_checksum DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .data_byte       (data_byte),
        .last_byte       (last_byte),
        .source_address  (source_address),
        .dest_address    (dest_address),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .checksum_result (checksum_result),
        .source_port     (source_port),
        .dest_port       (dest_port),
        .length_field    (length_field)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic udp_predict(input logic [7:0] b, input logic last,
                               input logic [31:0] sa, input logic [31:0] da,
                               output bit has_res, output udp_result_t res);
        int          kept;
        logic [47:0] hf;
        logic [63:0] total;
        has_res = 1'b0;
        res = '0;
        if (frm_count == 16'd0)
            frm_pseudo = sa[31:16] + sa[15:0] + da[31:16] + da[15:0] + UDP_PROTOCOL;
        if (frm_count < MAX_SEGMENT_COUNT)
        begin
            if (frm_count < KEEP_COUNT)
                frm_header = {frm_header[39:0], b};
            if (!frm_count[0])
                frm_high = b;
            else
            begin
                frm_word_sum = frm_word_sum + {16'h0000, frm_high, b};
                frm_high = 8'h00;
            end
            frm_count = frm_count + 16'd1;
        end
        if (last)
        begin
            kept = (frm_count < KEEP_COUNT) ? int'(frm_count) : HeaderKeepBytes;
            hf = frm_header << (8 * (HeaderKeepBytes - kept));
            res.sport = hf[47:32];
            res.dport = hf[31:16];
            res.len_field = hf[15:0];
            total = frm_word_sum + frm_pseudo + hf[15:0];
            if (frm_count[0])
                total = total + {frm_high, 8'h00};
            if (frm_count < HEADER_COUNT)
                res.status = STATUS_SHORT;
            else if (res.sport == 16'h0000)
                res.status = STATUS_SPORT_0;
            else if (res.dport == 16'h0000)
                res.status = STATUS_DPORT_0;
            else if (res.len_field > frm_count)
                res.status = STATUS_LEN_BIG;
            else
                res.status = STATUS_OK;
            while (total[63:16] != '0)
                total = total[15:0] + total[63:16];
            res.checksum = ~total[15:0];
            has_res = 1'b1;
            frm_count = '0;
            frm_header = '0;
            frm_word_sum = '0;
            frm_high = '0;
            frm_pseudo = '0;
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : watch_ports
        udp_result_t exp_res;
        udp_result_t new_res;
        bit          has_res;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, got status %0d sum %h",
                             $time, status, checksum_result);
                    mismatches++;
                end
                else
                begin
                    exp_res = pending_results.pop_front();
                    check_field("status", 16'(exp_res.status), 16'(status));
                    check_field("checksum_result", exp_res.checksum, checksum_result);
                    check_field("source_port", exp_res.sport, source_port);
                    check_field("dest_port", exp_res.dport, dest_port);
                    check_field("length_field", exp_res.len_field, length_field);
                end
            end
            if (in_valid && in_ready)
            begin
                udp_predict(data_byte, last_byte, source_address, dest_address,
                            has_res, new_res);
                if (has_res)
                    pending_results.push_back(row_typed ? row_want : new_res);
            end
        end
    end

    initial
    begin
        int stall;
        out_ready = 1'b0;
        while (!rst_n)
            @(negedge clk);
        forever
        begin
            @(negedge clk);
            if (rx_hold_len > 0)
            begin
                stall = rx_hold_len;
                rx_hold_len = 0;
            end
            else
                stall = no_idle ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    task automatic send_byte(input udp_byte_t it);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid       <= 1'b1;
        data_byte      <= it.data;
        last_byte      <= it.last;
        source_address <= it.sa;
        dest_address   <= it.da;
        row_typed = it.typed;
        row_want  = it.want;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic add_frame(input logic [7:0] fb[$], input logic [31:0] sa,
                             input logic [31:0] da, input logic typed,
                             input udp_result_t want);
        udp_byte_t it;
        for (int i = 0; i < fb.size(); i++)
        begin
            it.data  = fb[i];
            it.last  = (i == fb.size() - 1);
            it.sa    = (i == 0) ? sa : $urandom;
            it.da    = (i == 0) ? da : $urandom;
            it.typed = typed;
            it.want  = want;
            directed_rows.push_back(it);
        end
    endtask

    function automatic logic [31:0] pick_address();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] udp_checksum_fill(input logic [7:0] fb[$],
                                                      input logic [31:0] sa,
                                                      input logic [31:0] da);
        logic [63:0] acc;
        acc = sa[31:16] + sa[15:0] + da[31:16] + da[15:0] + UDP_PROTOCOL + {fb[4], fb[5]};
        for (int i = 0; i < fb.size(); i += 2)
            acc = acc + {fb[i], ((i + 1 < fb.size()) ? fb[i + 1] : 8'h00)};
        while (acc[63:16] != '0)
            acc = acc[15:0] + acc[63:16];
        return ~acc[15:0];
    endfunction

    task automatic send_random_frame();
        logic [7:0]  fb[$];
        logic [31:0] sa;
        logic [31:0] da;
        logic [15:0] sp;
        logic [15:0] dp;
        logic [15:0] ln;
        logic [15:0] ck;
        int          kind;
        int          plen;
        udp_byte_t   it;
        kind = $urandom_range(0, 9);
        sa = pick_address();
        da = pick_address();
        if (kind == 0)
        begin
            plen = $urandom_range(1, 7);
            repeat (plen) fb.push_back($urandom);
        end
        else
        begin
            plen = (kind == 1) ? $urandom_range(0, 40) : $urandom_range(0, 24);
            sp = ($urandom_range(0, 15) == 0) ? 16'h0000 : 16'($urandom_range(1, 65535));
            dp = ($urandom_range(0, 15) == 0) ? 16'h0000 : 16'($urandom_range(1, 65535));
            case ($urandom_range(0, 7))
                5:       ln = 16'(HeaderBytes + plen + 1);
                6:       ln = 16'($urandom_range(0, HeaderBytes - 1));
                7:       ln = $urandom;
                default: ln = 16'(HeaderBytes + plen);
            endcase
            if (kind == 1)
            begin
                sp = $urandom;
                dp = $urandom;
                ln = $urandom;
            end
            fb = '{sp[15:8], sp[7:0], dp[15:8], dp[7:0], ln[15:8], ln[7:0], 8'h00, 8'h00};
            repeat (plen) fb.push_back($urandom);
            if (kind != 1 && $urandom_range(0, 1) == 1)
                ck = udp_checksum_fill(fb, sa, da);
            else
                ck = $urandom;
            fb[6] = ck[15:8];
            fb[7] = ck[7:0];
        end
        for (int i = 0; i < fb.size(); i++)
        begin
            it = '0;
            it.data = fb[i];
            it.last = (i == fb.size() - 1);
            it.sa   = (i == 0) ? sa : $urandom;
            it.da   = (i == 0) ? da : $urandom;
            send_byte(it);
        end
        random_bytes += fb.size();
    endtask

    initial
    begin
        logic [7:0]  fb[$];
        udp_result_t want;
        udp_byte_t   it;
        int          phase;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        data_byte      = 8'h00;
        last_byte      = 1'b0;
        source_address = 32'h0;
        dest_address   = 32'h0;
        row_typed      = 1'b0;
        row_want       = '0;
        no_idle        = 1'b0;
        rx_hold_len    = 0;
        random_bytes   = 0;
        mismatches     = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // A single zero byte with zero addresses is too short; only the protocol is summed.
        fb = '{8'h00};
        want = '{STATUS_SHORT, 16'hFFEE, 16'h0000, 16'h0000, 16'h0000};
        add_frame(fb, 32'h0, 32'h0, 1'b1, want);
        fb = '{8'h00, 8'h00, 8'h12, 8'h34, 8'h00, 8'h08, 8'h00, 8'h00};
        want = '{STATUS_SPORT_0, 16'hEDAA, 16'h0000, 16'h1234, 16'h0008};
        add_frame(fb, 32'h0, 32'h0, 1'b1, want);
        fb = '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        add_frame(fb, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0);
        // A length below the header size is not flagged, and the odd last byte is padded.
        fb = '{8'h80, 8'h00, 8'h00, 8'h01, 8'h00, 8'h04, 8'h5A, 8'hA5, 8'hC3};
        add_frame(fb, 32'h1234_5678, 32'h9ABC_DEF0, 1'b0, '0);
        foreach (directed_rows[i])
            send_byte(directed_rows[i]);
        drain_results();

        phase = 0;
        while (random_bytes < 700)
        begin
            if (phase == 0 && random_bytes >= 150)
            begin
                // The receiver holds off while one-byte frames keep arriving.
                drain_results();
                rx_hold_len = 300;
                repeat (12)
                begin
                    it = '0;
                    it.data = $urandom;
                    it.last = 1'b1;
                    it.sa   = $urandom;
                    it.da   = $urandom;
                    send_byte(it);
                end
                phase = 1;
            end
            else if (phase == 1 && random_bytes >= 400)
            begin
                drain_results();
                no_idle = 1'b1;
                phase = 2;
            end
            else if (phase == 2 && random_bytes >= 520)
            begin
                no_idle = 1'b0;
                phase = 3;
            end
            send_random_frame();
        end
        drain_results();

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
